// File: sv/sqc_pkg.sv
package sqc_pkg;

	localparam int unsigned OP_W     = 3;
	localparam int unsigned DATA_W   = 8;
	localparam int unsigned SAMPLE_W = 16;

	typedef enum logic [2:0] {
		OP_TICK   = 3'd0,
		OP_LENGTH = 3'd1,
		OP_SWEEP  = 3'd2,
		OP_ENV    = 3'd3,
		OP_WRITE  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		REG_SWEEP    = 3'd0,
		REG_DUTY_LEN = 3'd1,
		REG_ENV      = 3'd2,
		REG_FREQ_LO  = 3'd3,
		REG_FREQ_HI  = 3'd4
	} reg_idx_t;

	localparam logic [11:0] FREQ_MAX   = 12'd2047;
	localparam logic [11:0] FREQ_LIMIT = 12'd2048;
	localparam logic [6:0]  LEN_FULL   = 7'd64;
	localparam logic [3:0]  VOL_MAX    = 4'd15;

	typedef struct packed {
		logic [2:0]  sweep_rate;
		logic        sweep_negate;
		logic [2:0]  sweep_shift_amt;
		logic [1:0]  duty_select;
		logic [6:0]  length_reload;
		logic [6:0]  length_left;
		logic [3:0]  env_start_vol;
		logic        env_up;
		logic [2:0]  env_rate;
		logic [10:0] freq_value;
		logic        length_enable;
		logic        wave_high;
		logic [2:0]  step_pos;
		logic [13:0] period_left;
		logic [2:0]  env_left;
		logic [2:0]  sweep_left;
		logic [11:0] shadow_freq;
		logic        sweep_on;
		logic [3:0]  vol_level;
		logic [15:0] sample_out;
	} chan_t;

	// 4 * (2048 - f)
	function automatic logic [13:0] period_of(logic [10:0] f);
		logic [11:0] diff;
		diff = FREQ_LIMIT - {1'b0, f};
		return {diff, 2'b00};
	endfunction

	// level * 4369 + 32768, mod 2^16
	function automatic logic [15:0] sample_of(logic [3:0] lvl);
		return {~lvl[3], lvl[2:0], lvl, lvl, lvl};
	endfunction

	function automatic logic duty_bit(logic [1:0] duty, logic [2:0] pos);
		logic b;
		case (duty)
			2'd0:    b = (pos == 3'd6);
			2'd1:    b = (pos >= 3'd6);
			2'd2:    b = (pos >= 3'd4);
			default: b = (pos <= 3'd5);
		endcase
		return b;
	endfunction

	function automatic chan_t sweep_once(chan_t s);
		chan_t       r;
		logic [11:0] off;
		logic [12:0] sum;
		r = s;
		if (s.sweep_on) begin
			off = s.shadow_freq >> s.sweep_shift_amt;
			if (s.sweep_negate) begin
				sum = (off > s.shadow_freq) ? 13'd0 : {1'b0, s.shadow_freq - off};
			end else begin
				sum = {1'b0, s.shadow_freq} + {1'b0, off};
			end
			if (sum > {1'b0, FREQ_MAX}) begin
				r.shadow_freq = FREQ_LIMIT;
				r.sweep_on    = 1'b0;
			end else begin
				r.shadow_freq = sum[11:0];
				if (s.sweep_shift_amt != 3'd0) begin
					r.freq_value  = sum[10:0];
					r.period_left = period_of(sum[10:0]);
				end
			end
		end
		return r;
	endfunction

endpackage

// File: sv/sqc_core.sv
module sqc_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [sqc_pkg::OP_W-1:0]      operation,
	input  logic [2:0]                    reg_index,
	input  logic [sqc_pkg::DATA_W-1:0]    write_data,
	output logic [sqc_pkg::SAMPLE_W-1:0]  sample_nxt
);
	import sqc_pkg::*;

	chan_t st_q;
	chan_t st_d;
	logic [3:0] lvl;

	always_comb begin
		st_d = st_q;
		lvl  = 4'd0;
		case (operation)
			OP_TICK: begin
				if (st_q.period_left != 14'd0) begin
					st_d.period_left = st_q.period_left - 14'd1;
					if (st_q.period_left == 14'd1) begin
						st_d.period_left = period_of(st_q.freq_value);
						st_d.step_pos    = st_q.step_pos + 3'd1;
						st_d.wave_high   = duty_bit(st_q.duty_select, st_d.step_pos);
					end
				end
				lvl = st_d.wave_high ? st_q.vol_level : 4'd0;
				if (st_q.length_enable && st_q.length_left == 7'd0) begin
					lvl = 4'd0;
				end
				st_d.sample_out = sample_of(lvl);
			end
			OP_LENGTH: begin
				if (st_q.length_enable && st_q.length_left != 7'd0) begin
					st_d.length_left = st_q.length_left - 7'd1;
				end
			end
			OP_SWEEP: begin
				if (st_q.sweep_rate != 3'd0 && st_q.sweep_left != 3'd0) begin
					st_d.sweep_left = st_q.sweep_left - 3'd1;
					if (st_q.sweep_left == 3'd1) begin
						st_d.sweep_left = st_q.sweep_rate;
						st_d = sweep_once(st_d);
					end
				end
			end
			OP_ENV: begin
				if (st_q.env_left != 3'd0) begin
					st_d.env_left = st_q.env_left - 3'd1;
					if (st_q.env_left == 3'd1) begin
						st_d.env_left = st_q.env_rate;
						if (!st_q.env_up && st_q.vol_level != 4'd0) begin
							st_d.vol_level = st_q.vol_level - 4'd1;
						end
						if (st_q.env_up && st_q.vol_level != VOL_MAX) begin
							st_d.vol_level = st_q.vol_level + 4'd1;
						end
					end
				end
			end
			OP_WRITE: begin
				case (reg_index)
					REG_SWEEP: begin
						st_d.sweep_rate      = write_data[6:4];
						st_d.sweep_negate    = write_data[3];
						st_d.sweep_shift_amt = write_data[2:0];
					end
					REG_DUTY_LEN: begin
						st_d.duty_select   = write_data[7:6];
						st_d.length_reload = LEN_FULL - {1'b0, write_data[5:0]};
						st_d.length_left   = st_d.length_reload;
					end
					REG_ENV: begin
						st_d.env_start_vol = write_data[7:4];
						st_d.env_up        = write_data[3];
						st_d.env_rate      = write_data[2:0];
					end
					REG_FREQ_LO: begin
						st_d.freq_value = {st_q.freq_value[10:8], write_data};
					end
					REG_FREQ_HI: begin
						st_d.length_enable = write_data[6];
						st_d.freq_value    = {write_data[2:0], st_q.freq_value[7:0]};
						if (write_data[7]) begin
							st_d.length_left = st_q.length_reload;
							st_d.env_left    = st_q.env_rate;
							st_d.vol_level   = st_q.env_start_vol;
							st_d.shadow_freq = {1'b0, st_d.freq_value};
							st_d.sweep_left  = st_q.sweep_rate;
							st_d.sweep_on    = (st_q.sweep_rate != 3'd0) ||
								(st_q.sweep_shift_amt != 3'd0);
							if (st_q.sweep_shift_amt != 3'd0) begin
								st_d = sweep_once(st_d);
							end
						end
					end
					default: begin
					end
				endcase
				st_d.period_left = period_of(st_d.freq_value);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (accept) begin
			st_q <= st_d;
		end
	end

	assign sample_nxt = st_d.sample_out;

endmodule

// File: sv/sqc_outreg.sv
module sqc_outreg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [sqc_pkg::SAMPLE_W-1:0]  sample_nxt,
	input  logic                          result_ready,
	output logic                          result_valid,
	output logic                          item_ready,
	output logic [sqc_pkg::SAMPLE_W-1:0]  sample
);
	import sqc_pkg::*;

	logic                valid_q;
	logic [SAMPLE_W-1:0] sample_q;

	assign item_ready = !valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample_nxt;
		end
	end

	assign result_valid = valid_q;
	assign sample       = sample_q;

endmodule

// File: sv/square_wave_channel_with_sweep.sv
// Square-wave channel with sweep, envelope and length counter.
// result_valid is registered and rises in the cycle after the item transfer.
// Throughput: one item per cycle, set by the single channel state register,
// while item_ready is high; it drops while a result is held and result_ready is low.
// Reset (arst_n low): all channel state clears to zero and no result is pending; the sample register is not reset.
module square_wave_channel_with_sweep (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic [sqc_pkg::OP_W-1:0]      operation,
	input  logic [2:0]                    reg_index,
	input  logic [sqc_pkg::DATA_W-1:0]    write_data,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic signed [sqc_pkg::SAMPLE_W-1:0] sample
);
	import sqc_pkg::*;

	logic                accept;
	logic [SAMPLE_W-1:0] sample_nxt;
	logic [SAMPLE_W-1:0] sample_raw;

	assign accept = item_valid && item_ready;

	sqc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.operation  (operation),
		.reg_index  (reg_index),
		.write_data (write_data),
		.sample_nxt (sample_nxt)
	);

	sqc_outreg u_outreg (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.sample_nxt   (sample_nxt),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.item_ready   (item_ready),
		.sample       (sample_raw)
	);

	assign sample = signed'(sample_raw);

endmodule

// File: tb/tb_square_wave_channel_with_sweep.sv
module tb_square_wave_channel_with_sweep;
	import sqc_pkg::*;

	localparam int          CYCLE_LIMIT = 200000;
	localparam int          ITEM_TARGET = 1200;
	localparam logic [2:0]  OP_RSVD     = 3'd7;
	localparam logic [2:0]  REG_RSVD    = 3'd7;

	class chan_scoreboard;
		bit [2:0]  swp_rate;
		bit        swp_neg;
		bit [2:0]  swp_shift;
		bit [1:0]  duty;
		bit [6:0]  len_load;
		bit [6:0]  len_cnt;
		bit [3:0]  env_init;
		bit        env_inc;
		bit [2:0]  env_period;
		bit [10:0] freq;
		bit        len_en;
		bit        duty_out;
		bit [2:0]  phase;
		bit [13:0] period_cnt;
		bit [2:0]  env_cnt;
		bit [2:0]  swp_cnt;
		bit [11:0] shadow;
		bit        swp_active;
		bit [3:0]  volume;
		bit [15:0] level_out;
		bit [15:0] samples_due[$];
		int        errors;

		function bit [13:0] period_for(bit [10:0] f);
			return 14'(4 * (2048 - int'(f)));
		endfunction

		function void sweep_step();
			int off;
			int nf;
			if (!swp_active)
				return;
			off = int'(shadow >> swp_shift);
			nf = swp_neg ? int'(shadow) - off : int'(shadow) + off;
			if (nf < 0)
				nf = 0;
			if (nf > 2047) begin
				shadow = 12'd2048;
				swp_active = 1'b0;
			end else begin
				shadow = 12'(nf);
				if (swp_shift != 3'd0) begin
					freq = 11'(nf);
					period_cnt = period_for(freq);
				end
			end
		endfunction

		function void tick_step();
			bit [3:0] lvl;
			if (period_cnt != 0) begin
				period_cnt--;
				if (period_cnt == 0) begin
					period_cnt = period_for(freq);
					phase++;
					case (duty)
						2'd0: duty_out = (phase == 3'd6);
						2'd1: duty_out = (phase >= 3'd6);
						2'd2: duty_out = (phase >= 3'd4);
						default: duty_out = (phase <= 3'd5);
					endcase
				end
			end
			lvl = duty_out ? volume : 4'd0;
			if (len_en && len_cnt == 0)
				lvl = 4'd0;
			level_out = 16'(int'(lvl) * 4369 + 32768);
		endfunction

		function void reg_write(bit [2:0] r, bit [7:0] d);
			case (r)
				REG_SWEEP: begin
					swp_rate = d[6:4];
					swp_neg = d[3];
					swp_shift = d[2:0];
				end
				REG_DUTY_LEN: begin
					duty = d[7:6];
					len_load = 7'(7'd64 - {1'b0, d[5:0]});
					len_cnt = len_load;
				end
				REG_ENV: begin
					env_init = d[7:4];
					env_inc = d[3];
					env_period = d[2:0];
				end
				REG_FREQ_LO: freq[7:0] = d;
				REG_FREQ_HI: begin
					len_en = d[6];
					freq[10:8] = d[2:0];
					if (d[7]) begin
						len_cnt = len_load;
						env_cnt = env_period;
						volume = env_init;
						shadow = {1'b0, freq};
						swp_cnt = swp_rate;
						swp_active = (swp_cnt != 0 || swp_shift != 0);
						if (swp_shift != 0)
							sweep_step();
					end
				end
				default: ;
			endcase
			period_cnt = period_for(freq);
		endfunction

		function void note_item(bit [2:0] op, bit [2:0] r, bit [7:0] d);
			case (op)
				OP_TICK: tick_step();
				OP_LENGTH: begin
					if (len_en && len_cnt != 0)
						len_cnt--;
				end
				OP_SWEEP: begin
					if (swp_rate != 0 && swp_cnt != 0) begin
						swp_cnt--;
						if (swp_cnt == 0) begin
							swp_cnt = swp_rate;
							sweep_step();
						end
					end
				end
				OP_ENV: begin
					if (env_cnt != 0) begin
						env_cnt--;
						if (env_cnt == 0) begin
							env_cnt = env_period;
							if (!env_inc && volume > 0)
								volume--;
							if (env_inc && volume < 15)
								volume++;
						end
					end
				end
				OP_WRITE: reg_write(r, d);
				default: ;
			endcase
			samples_due.push_back(level_out);
		endfunction

		task report(string msg);
			errors++;
			$display("%0t mismatch: %s", $time, msg);
		endtask

		task check_sample(logic [15:0] s);
			bit [15:0] want;
			if (samples_due.size() == 0) begin
				report($sformatf("unexpected result, sample %0d", $signed(s)));
				return;
			end
			want = samples_due.pop_front();
			if (s !== want)
				report($sformatf("sample %0d, predicted %0d", $signed(s), $signed(want)));
		endtask

		function int outstanding();
			return samples_due.size();
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      item_valid = 1'b0;
	logic                      item_ready;
	logic [OP_W-1:0]           operation = '0;
	logic [2:0]                reg_index = '0;
	logic [DATA_W-1:0]         write_data = '0;
	logic                      result_valid;
	logic                      result_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] sample;

	chan_scoreboard sb;
	bit             no_idle;
	int             items_sent;
	int             cycle_cnt;

	square_wave_channel_with_sweep u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.operation    (operation),
		.reg_index    (reg_index),
		.write_data   (write_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.sample       (sample)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("square_wave_channel_with_sweep verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready)
				sb.note_item(operation, reg_index, write_data);
			if (result_valid && result_ready)
				sb.check_sample(sample);
		end
	end

	function automatic int draw_wait();
		return no_idle ? 0 : int'($urandom_range(0, 6));
	endfunction

	initial begin
		int w;
		forever begin
			w = draw_wait();
			if (w > 0) begin
				result_ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!(result_valid && result_ready));
		end
	end

	task automatic send_item(input logic [2:0] op, input logic [2:0] r, input logic [7:0] d);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		operation <= op;
		reg_index <= r;
		write_data <= d;
		do @(posedge clk); while (!item_ready);
		items_sent++;
	endtask

	task automatic write_reg(input logic [2:0] r, input logic [7:0] d);
		send_item(OP_WRITE, r, d);
	endtask

	// mostly short periods so the duty phase moves within a burst
	function automatic logic [10:0] pick_freq();
		if ($urandom_range(0, 3) == 0)
			return 11'($urandom_range(0, 2047));
		return 11'($urandom_range(2032, 2047));
	endfunction

	initial begin
		logic [10:0] f;
		int          pick;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle period counter, reserved codes, extremes
		no_idle = 1'b0;
		send_item(OP_TICK, REG_SWEEP, 8'h00);
		send_item(OP_RSVD, REG_RSVD, 8'hFF);
		write_reg(REG_ENV, 8'hF0);
		write_reg(REG_DUTY_LEN, 8'hBF);
		write_reg(REG_FREQ_LO, 8'hFF);
		write_reg(REG_SWEEP, 8'h00);
		write_reg(REG_FREQ_HI, 8'hC7);
		repeat (5) send_item(OP_TICK, REG_SWEEP, 8'h00);
		send_item(OP_LENGTH, REG_SWEEP, 8'h00);
		send_item(OP_TICK, REG_SWEEP, 8'h00);
		// sweep overflow right at trigger
		write_reg(REG_SWEEP, 8'h11);
		write_reg(REG_FREQ_HI, 8'h87);
		// negate down to zero
		write_reg(REG_SWEEP, 8'h7F);
		write_reg(REG_FREQ_LO, 8'h00);
		write_reg(REG_FREQ_HI, 8'h80);
		send_item(OP_SWEEP, REG_SWEEP, 8'h00);
		// zero shift, rate set; envelope upward
		write_reg(REG_SWEEP, 8'h70);
		write_reg(REG_ENV, 8'h09);
		write_reg(REG_FREQ_HI, 8'hBF);
		send_item(OP_ENV, REG_SWEEP, 8'h00);
		send_item(OP_SWEEP, REG_SWEEP, 8'h00);
		write_reg(REG_RSVD, 8'hFF);

		while (items_sent < ITEM_TARGET) begin
			no_idle = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(5, 20))
					send_item(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), 8'($urandom));
			end else begin
				f = pick_freq();
				if ($urandom_range(0, 1))
					write_reg(REG_SWEEP, 8'($urandom));
				write_reg(REG_DUTY_LEN, 8'($urandom));
				if ($urandom_range(0, 1))
					write_reg(REG_ENV, 8'($urandom));
				write_reg(REG_FREQ_LO, f[7:0]);
				write_reg(REG_FREQ_HI, {1'b1, 1'($urandom), 3'($urandom), f[10:8]});
				repeat ($urandom_range(10, 60)) begin
					pick = $urandom_range(0, 99);
					if (pick < 60)
						send_item(OP_TICK, 3'($urandom), 8'($urandom));
					else if (pick < 72)
						send_item(OP_LENGTH, 3'($urandom), 8'($urandom));
					else if (pick < 84)
						send_item(OP_SWEEP, 3'($urandom), 8'($urandom));
					else if (pick < 96)
						send_item(OP_ENV, 3'($urandom), 8'($urandom));
					else
						write_reg(3'($urandom_range(0, 7)), 8'($urandom));
				end
			end
		end
		item_valid <= 1'b0;

		// the last transfer is noted at the edge it returned on
		do @(posedge clk); while (sb.outstanding() != 0);
		repeat (5) @(posedge clk);
		if (sb.errors == 0)
			$display("square_wave_channel_with_sweep verification clean");
		else
			$display("square_wave_channel_with_sweep verification failed");
		$finish;
	end

endmodule

// File: sim.f
sv/sqc_pkg.sv
sv/sqc_core.sv
sv/sqc_outreg.sv
sv/square_wave_channel_with_sweep.sv
tb/tb_square_wave_channel_with_sweep.sv
